// ===== rtl/core/ifssa_pkg.sv =====
// Shared types and constants for the interrupt flag shadow stack audit block.
package ifssa_pkg;

   localparam int IF_BIT = 9;
   localparam int ADDR_W = 64;
   localparam int BOUND_W = 48;
   localparam int LIMIT_W = 7;
   localparam int CSR_INDEX_W = 2;

   localparam logic [BOUND_W-1:0] LOW_BOUND_RESET = 48'h0000_0001_0000;
   localparam logic [BOUND_W-1:0] HIGH_LIMIT_RESET = 48'h8000_0000_0000;
   localparam logic [LIMIT_W-1:0] REPORT_LIMIT_RESET = 7'd64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CALLER_LOW_BOUND = 2'd0,
      CSR_CALLER_HIGH_LIMIT = 2'd1,
      CSR_REPORT_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      EVT_NONE = 2'd0,
      EVT_ENTRY_IRQ_OFF = 2'd1,
      EVT_EXIT_IRQ_LEAK = 2'd2
   } event_code_type;

   localparam logic KIND_ENTRY = 1'b0;
   localparam logic KIND_EXIT = 1'b1;

   typedef struct packed {
      logic kind;
      logic signed [15:0] task_id;
      logic [ADDR_W-1:0] function_addr;
      logic [ADDR_W-1:0] caller_pc;
      logic [ADDR_W-1:0] cpu_flags;
   } req_type;

   typedef struct packed {
      logic [1:0] event_code;
      logic [ADDR_W-1:0] report_function;
      logic [ADDR_W-1:0] report_caller;
      logic [ADDR_W-1:0] report_entry_flags;
      logic [ADDR_W-1:0] report_exit_flags;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] function_addr;
      logic [ADDR_W-1:0] caller;
      logic [ADDR_W-1:0] flags_at_entry;
      logic boundary;
   } frame_type;

endpackage

// ===== rtl/core/ifssa_depth_ram.sv =====
// Per-task stack depth memory, one write and one registered read port.
module ifssa_depth_ram #(
   parameter int ENTRIES = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [ENTRIES];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ifssa_frame_ram.sv =====
// Shadow stack frame memory for all tasks, one write and one registered read port.
module ifssa_frame_ram #(
   parameter int ENTRIES = 8192,
   parameter int ADDR_W = 13
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  ifssa_pkg::frame_type wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output ifssa_pkg::frame_type rd_data
);

   ifssa_pkg::frame_type mem [ENTRIES];
   ifssa_pkg::frame_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/interrupt_flag_shadow_stack_audit_core.sv =====
// The result is registered after the depth read, the frame read and the update, in that order.
// Each event does a depth read then a frame read in turn; a new request waits for its update.
// A waiting result does not block the next request; the update stalls only if it is still held.
// Reset: synchronous; clears control state, then zeroes each depth memory entry in turn,
// during which no request is taken (config writes are taken throughout).
module interrupt_flag_shadow_stack_audit_core #(
   parameter int TASK_COUNT = 256,
   parameter int STACK_DEPTH_MAX = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  ifssa_pkg::req_type                        req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output ifssa_pkg::rsp_type                        rsp_data,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [ifssa_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [ifssa_pkg::BOUND_W-1:0]             csr_wdata
);

   localparam int TW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int SLOTS = TASK_COUNT * STACK_DEPTH_MAX;
   localparam int AW = $clog2(SLOTS);
   localparam int DW = $clog2(STACK_DEPTH_MAX + 1);
   localparam int LW = ifssa_pkg::LIMIT_W;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_DEPTH = 4'b0100,
      S_FRAME = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [ifssa_pkg::BOUND_W-1:0] low_bound_ff;
   logic [ifssa_pkg::BOUND_W-1:0] high_limit_ff;
   logic [LW-1:0] report_limit_ff;
   logic [LW-1:0] reports_made_ff, reports_made_in;

   ifssa_pkg::req_type item_ff;
   logic skip_ff;
   logic [TW-1:0] task_ff;
   logic [AW-1:0] base_ff;
   logic [DW-1:0] eff_ff, eff_in;
   logic [TW-1:0] clr_ff;

   logic rsp_valid_ff, rsp_valid_in;
   ifssa_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic req_xfer, rsp_xfer, finish, in_window, task_ok;
   logic [TW-1:0] req_task;

   logic          depth_wr_en, depth_rd_en;
   logic [TW-1:0] depth_wr_addr;
   logic [DW-1:0] depth_wr_data, depth_rd_data;

   logic                 frame_wr_en, frame_rd_en;
   logic [AW-1:0]        frame_wr_addr, frame_rd_addr;
   ifssa_pkg::frame_type frame_wr_data, frame_rd_data;

   logic is_entry, boundary, match, hit, emit;
   logic [1:0] hit_code;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid_ff && rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Request screening at the transfer
   assign in_window = (req_data.caller_pc >= {16'b0, low_bound_ff}) &&
                      (req_data.caller_pc < {16'b0, high_limit_ff});
   assign task_ok = !req_data.task_id[15] &&
                    ({1'b0, req_data.task_id} < 17'(TASK_COUNT));
   assign req_task = req_data.task_id[TW-1:0];

   // Entry on a full stack restarts it from empty
   always_comb begin
      eff_in = depth_rd_data;
      if (item_ff.kind == ifssa_pkg::KIND_ENTRY && depth_rd_data >= DW'(STACK_DEPTH_MAX)) begin
         eff_in = '0;
      end
   end

   assign depth_rd_en = req_xfer;
   assign frame_rd_en = (state_ff == S_DEPTH);
   assign frame_rd_addr = base_ff + AW'(eff_in) - AW'(1);

   assign finish = (state_ff == S_FRAME) && (!rsp_valid_ff || rsp_ready);
   assign is_entry = (item_ff.kind == ifssa_pkg::KIND_ENTRY);
   assign boundary = (eff_ff == '0) || (frame_rd_data.caller != item_ff.caller_pc);
   assign match = (frame_rd_data.function_addr == item_ff.function_addr) &&
                  (frame_rd_data.caller == item_ff.caller_pc);

   always_comb begin
      hit = 1'b0;
      hit_code = ifssa_pkg::EVT_NONE;
      if (is_entry) begin
         hit = boundary && !item_ff.cpu_flags[ifssa_pkg::IF_BIT];
         hit_code = ifssa_pkg::EVT_ENTRY_IRQ_OFF;
      end else begin
         hit = (eff_ff != '0) && match && frame_rd_data.boundary &&
               frame_rd_data.flags_at_entry[ifssa_pkg::IF_BIT] &&
               !item_ff.cpu_flags[ifssa_pkg::IF_BIT];
         hit_code = ifssa_pkg::EVT_EXIT_IRQ_LEAK;
      end
   end

   assign emit = finish && !skip_ff && hit && (reports_made_ff < report_limit_ff);

   always_comb begin
      frame_wr_en = finish && !skip_ff && is_entry;
      frame_wr_addr = base_ff + AW'(eff_ff);
      frame_wr_data.function_addr = item_ff.function_addr;
      frame_wr_data.caller = item_ff.caller_pc;
      frame_wr_data.flags_at_entry = item_ff.cpu_flags;
      frame_wr_data.boundary = boundary;
   end

   always_comb begin
      depth_wr_en = 1'b0;
      depth_wr_addr = task_ff;
      depth_wr_data = '0;
      if (state_ff == S_CLEAR) begin
         depth_wr_en = 1'b1;
         depth_wr_addr = clr_ff;
      end else if (finish && !skip_ff && (is_entry || eff_ff != '0)) begin
         depth_wr_en = 1'b1;
         if (is_entry) begin
            depth_wr_data = eff_ff + DW'(1);
         end else if (match) begin
            depth_wr_data = eff_ff - DW'(1);
         end else begin
            depth_wr_data = '0;
         end
      end
   end

   always_comb begin
      rsp_data_in = '0;
      if (emit) begin
         rsp_data_in.event_code = hit_code;
         rsp_data_in.report_exit_flags = item_ff.cpu_flags;
         if (is_entry) begin
            rsp_data_in.report_function = item_ff.function_addr;
            rsp_data_in.report_caller = item_ff.caller_pc;
            rsp_data_in.report_entry_flags = item_ff.cpu_flags;
         end else begin
            rsp_data_in.report_function = frame_rd_data.function_addr;
            rsp_data_in.report_caller = frame_rd_data.caller;
            rsp_data_in.report_entry_flags = frame_rd_data.flags_at_entry;
         end
      end
   end

   assign reports_made_in = emit ? reports_made_ff + LW'(1) : reports_made_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == TW'(TASK_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_DEPTH;
            end
         end
         S_DEPTH: state_in = S_FRAME;
         S_FRAME: begin
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         reports_made_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_ff <= clr_ff + TW'(1);
         end
         rsp_valid_ff <= rsp_valid_in;
         reports_made_ff <= reports_made_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_bound_ff <= ifssa_pkg::LOW_BOUND_RESET;
         high_limit_ff <= ifssa_pkg::HIGH_LIMIT_RESET;
         report_limit_ff <= ifssa_pkg::REPORT_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ifssa_pkg::CSR_CALLER_LOW_BOUND:  low_bound_ff <= csr_wdata;
            ifssa_pkg::CSR_CALLER_HIGH_LIMIT: high_limit_ff <= csr_wdata;
            ifssa_pkg::CSR_REPORT_LIMIT:      report_limit_ff <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_ff <= req_data;
         skip_ff <= !(in_window && task_ok);
         task_ff <= req_task;
         base_ff <= AW'(int'(req_task) * STACK_DEPTH_MAX);
      end
      if (state_ff == S_DEPTH) begin
         eff_ff <= eff_in;
      end
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   ifssa_depth_ram #(
      .ENTRIES(TASK_COUNT),
      .ADDR_W(TW),
      .DATA_W(DW)
   ) u_depth_ram (
      .clock(clock),
      .wr_en(depth_wr_en),
      .wr_addr(depth_wr_addr),
      .wr_data(depth_wr_data),
      .rd_en(depth_rd_en),
      .rd_addr(req_task),
      .rd_data(depth_rd_data)
   );

   ifssa_frame_ram #(
      .ENTRIES(SLOTS),
      .ADDR_W(AW)
   ) u_frame_ram (
      .clock(clock),
      .wr_en(frame_wr_en),
      .wr_addr(frame_wr_addr),
      .wr_data(frame_wr_data),
      .rd_en(frame_rd_en),
      .rd_addr(frame_rd_addr),
      .rd_data(frame_rd_data)
   );

   a_req_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_DEPTH)
      else $error("request transfer did not start a depth lookup");

   a_result_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FRAME))
      else $error("result raised outside the update step");

   a_report_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && reports_made_ff != $past(reports_made_ff) |->
         reports_made_ff == $past(reports_made_ff) + LW'(1) &&
         $past(reports_made_ff) < $past(report_limit_ff))
      else $error("report count moved other than by one below the limit");

endmodule
